@@ rtl/spv_pkg.sv @@
// Shared types, codes and tables of the sample playback voice.
`timescale 1ns / 1ps

package spv_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_START,
		KIND_STOP,
		KIND_TICK
	} item_kind_t;

	typedef enum logic [1:0] {
		CURVE_LINEAR,
		CURVE_SQUARE,
		CURVE_SQRT,
		CURVE_COSINE
	} curve_t;

	localparam logic [1:0] MODE_LOOP     = 2'd1;
	localparam logic [1:0] MODE_PINGPONG = 2'd2;

	localparam logic [2:0] REG_START     = 3'd0;
	localparam logic [2:0] REG_END       = 3'd1;
	localparam logic [2:0] REG_LENGTH    = 3'd2;
	localparam logic [2:0] REG_STEP      = 3'd3;
	localparam logic [2:0] REG_GAIN      = 3'd4;
	localparam logic [2:0] REG_MODE      = 3'd5;
	localparam logic [2:0] REG_FADE_IN   = 3'd6;
	localparam logic [2:0] REG_FADE_OUT  = 3'd7;

	localparam logic [16:0] UNITY     = 17'd65536;
	localparam logic [3:0]  ITER_LAST = 4'd15;

	localparam logic [16:0] COS_TAB [33] = '{
		17'd0,     17'd158,   17'd630,   17'd1411,  17'd2494,  17'd3869,
		17'd5522,  17'd7438,  17'd9598,  17'd11980, 17'd14563, 17'd17321,
		17'd20228, 17'd23256, 17'd26375, 17'd29556, 17'd32768, 17'd35980,
		17'd39161, 17'd42280, 17'd45308, 17'd48215, 17'd50973, 17'd53556,
		17'd55938, 17'd58098, 17'd60014, 17'd61667, 17'd63042, 17'd64125,
		17'd64906, 17'd65378, 17'd65536
	};

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_START,
		ST_STOP,
		ST_BOUND,
		ST_FSETUP,
		ST_DIV,
		ST_SQRT_LOAD,
		ST_SQRT,
		ST_MUL_SQ,
		ST_MUL_COS,
		ST_FSTORE,
		ST_MUL_FT,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_MUL_INT,
		ST_ACC,
		ST_MUL_AMP,
		ST_RND,
		ST_MUL_GAIN,
		ST_ADVANCE,
		ST_FINISH
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_RANGE,
		OP_START,
		OP_STOP,
		OP_BOUND,
		OP_FSETUP,
		OP_DIV,
		OP_SQRT_LOAD,
		OP_SQRT,
		OP_MUL_SQ,
		OP_MUL_COS,
		OP_FSTORE,
		OP_MUL_FT,
		OP_RD0,
		OP_RD1,
		OP_RD2,
		OP_MUL_INT,
		OP_ACC,
		OP_MUL_AMP,
		OP_RND,
		OP_MUL_GAIN,
		OP_ADVANCE,
		OP_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		item_kind_t kind;
		logic       active;
		logic       stop;
		logic       bypass;
		logic       fsel;
		curve_t     curve;
	} status_t;

endpackage

@@ rtl/spv_in_if.sv @@
// Input item channel of the sample playback voice.
`timescale 1ns / 1ps

interface spv_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  kind;
	logic        [15:0] address;
	logic signed [15:0] sample_in;
	logic signed [23:0] mix_in;

	modport source (output valid, kind, address, sample_in, mix_in, input ready);
	modport sink (input valid, kind, address, sample_in, mix_in, output ready);
endinterface

@@ rtl/spv_out_if.sv @@
// Result channel of the sample playback voice.
`timescale 1ns / 1ps

interface spv_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] mix_out;
	logic signed [15:0] voice_sample;
	logic               voice_active;
	logic        [15:0] position_index;

	modport source (output valid, mix_out, voice_sample, voice_active, position_index,
		input ready);
	modport sink (input valid, mix_out, voice_sample, voice_active, position_index,
		output ready);
endinterface

@@ rtl/spv_cfg_if.sv @@
// Configuration write channel of the sample playback voice.
`timescale 1ns / 1ps

interface spv_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/spv_ctrl.sv @@
// Sequencing state machine of the sample playback voice.
`timescale 1ns / 1ps

module spv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  spv_pkg::status_t status,
	output spv_pkg::cmd_t    cmd
);
	import spv_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.op == OP_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.op = OP_RANGE;
				case (status.kind)
					KIND_START: state_d = ST_START;
					KIND_STOP:  state_d = ST_STOP;
					KIND_TICK:  state_d = status.active ? ST_BOUND : ST_FINISH;
					default:    state_d = ST_FINISH;
				endcase
			end
			ST_START: begin
				cmd.op  = OP_START;
				state_d = ST_FINISH;
			end
			ST_STOP: begin
				cmd.op  = OP_STOP;
				state_d = ST_FINISH;
			end
			ST_BOUND: begin
				cmd.op  = OP_BOUND;
				state_d = status.stop ? ST_FINISH : ST_FSETUP;
			end
			ST_FSETUP: begin
				cmd.op  = OP_FSETUP;
				cnt_d   = '0;
				state_d = status.bypass ? ST_FSTORE : ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q == ITER_LAST) begin
					case (status.curve)
						CURVE_SQUARE: state_d = ST_MUL_SQ;
						CURVE_SQRT:   state_d = ST_SQRT_LOAD;
						CURVE_COSINE: state_d = ST_MUL_COS;
						default:      state_d = ST_FSTORE;
					endcase
				end
			end
			ST_SQRT_LOAD: begin
				cmd.op  = OP_SQRT_LOAD;
				cnt_d   = '0;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT;
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q == ITER_LAST) begin
					state_d = ST_FSTORE;
				end
			end
			ST_MUL_SQ: begin
				cmd.op  = OP_MUL_SQ;
				state_d = ST_FSTORE;
			end
			ST_MUL_COS: begin
				cmd.op  = OP_MUL_COS;
				state_d = ST_FSTORE;
			end
			ST_FSTORE: begin
				cmd.op  = OP_FSTORE;
				state_d = status.fsel ? ST_MUL_FT : ST_FSETUP;
			end
			ST_MUL_FT: begin
				cmd.op  = OP_MUL_FT;
				state_d = ST_RD0;
			end
			ST_RD0: begin
				cmd.op  = OP_RD0;
				state_d = ST_RD1;
			end
			ST_RD1: begin
				cmd.op  = OP_RD1;
				state_d = ST_RD2;
			end
			ST_RD2: begin
				cmd.op  = OP_RD2;
				state_d = ST_MUL_INT;
			end
			ST_MUL_INT: begin
				cmd.op  = OP_MUL_INT;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.op  = OP_ACC;
				state_d = ST_MUL_AMP;
			end
			ST_MUL_AMP: begin
				cmd.op  = OP_MUL_AMP;
				state_d = ST_RND;
			end
			ST_RND: begin
				cmd.op  = OP_RND;
				state_d = ST_MUL_GAIN;
			end
			ST_MUL_GAIN: begin
				cmd.op  = OP_MUL_GAIN;
				state_d = ST_ADVANCE;
			end
			ST_ADVANCE: begin
				cmd.op  = OP_ADVANCE;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/spv_dp.sv @@
// Datapath of the sample playback voice: registers, sample memory and arithmetic.
`timescale 1ns / 1ps

module spv_dp #(
	parameter int MEMORY_DEPTH = 65536,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spv_pkg::cmd_t      cmd,
	output spv_pkg::status_t   status,
	input  logic               cfg_valid,
	input  logic        [2:0]  cfg_index,
	input  logic        [23:0] cfg_data,
	input  logic        [1:0]  kind,
	input  logic        [15:0] address,
	input  logic signed [15:0] sample_in,
	input  logic signed [23:0] mix_in,
	output logic signed [23:0] mix_out,
	output logic signed [15:0] voice_sample,
	output logic               voice_active,
	output logic        [15:0] position_index
);
	import spv_pkg::*;

	localparam int          AW      = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;
	localparam logic [24:0] DEPTH_V = 25'(MEMORY_DEPTH);
	localparam int          SH      = 24 - SAMPLE_BITS;

	logic signed [15:0] mem [MEMORY_DEPTH];

	// configuration
	logic [15:0] start_q;
	logic [16:0] end_q, len_q, fin_q, fout_q;
	logic [23:0] step_q;
	logic [15:0] gain_q;
	logic [6:0]  mode_q;

	// voice state
	logic [31:0] p_q;
	logic        back_q, active_q, fsel_q;

	// working registers
	logic [1:0]         kind_q;
	logic signed [23:0] mix_q;
	logic [16:0]        s_q, e_q, l_q;
	logic [32:0]        rem_q, dv_q;
	logic [15:0]        q_q;
	logic               byp_q;
	logic [31:0]        rad_q;
	logic [17:0]        rm_q;
	logic [15:0]        root_q;
	logic [16:0]        fi_q, fo_q, ft_q;
	logic signed [15:0] rdata_q, s1_q, s2_q;
	logic               rd_ok_q;
	logic signed [33:0] acc_q, a1_q;
	logic signed [51:0] mul_q;
	logic signed [21:0] voice_q;
	logic signed [23:0] out_mix_q;
	logic signed [15:0] out_voice_q;
	logic               out_active_q;
	logic [15:0]        out_pos_q;

	// range
	logic [16:0] l_c, lm1_c, s_c, e_c;

	always_comb begin
		if (len_q < 17'd2) begin
			l_c = 17'd2;
		end else if (len_q > UNITY) begin
			l_c = UNITY;
		end else begin
			l_c = len_q;
		end
		lm1_c = l_c - 17'd1;
		s_c   = ({1'b0, start_q} < lm1_c) ? {1'b0, start_q} : lm1_c;
		e_c   = (end_q < l_c) ? end_q : l_c;
		if (e_c <= s_c) begin
			s_c = '0;
			e_c = l_c;
		end
	end

	// boundary rule
	logic [16:0] em1_c, em2_c, sp1_c, lm1_q_c;
	logic [31:0] top_c, thr_fwd_c, thr_bwd_c, refl_fwd_c, refl_bwd_c;
	logic        hit_fwd_c, hit_bwd_c, stop_c;

	always_comb begin
		em1_c      = e_q - 17'd1;
		em2_c      = e_q - 17'd2;
		sp1_c      = s_q + 17'd1;
		lm1_q_c    = l_q - 17'd1;
		top_c      = {lm1_q_c[15:0], 16'b0};
		thr_fwd_c  = {em1_c[15:0], 16'b0};
		thr_bwd_c  = {s_q[15:0], 16'b0};
		refl_fwd_c = (e_q < 17'd2) ? 32'd0 : {em2_c[15:0], 16'b0};
		refl_bwd_c = (sp1_c > lm1_q_c) ? top_c : {sp1_c[15:0], 16'b0};
		hit_fwd_c  = !back_q && (p_q >= thr_fwd_c);
		hit_bwd_c  = back_q && (p_q <= thr_bwd_c);
		stop_c     = (mode_q[1:0] != MODE_LOOP) && (mode_q[1:0] != MODE_PINGPONG)
			&& (hit_fwd_c || hit_bwd_c);
	end

	// fade set-up
	logic [16:0]        span_c, nraw_c, n_c;
	logic [32:0]        span_fx_c, d_c, x_c, nfx_c;
	logic signed [33:0] rel_c;
	logic               bypass_c;

	always_comb begin
		span_c    = e_q - s_q;
		span_fx_c = {span_c, 16'b0};
		rel_c     = $signed({2'b0, p_q}) - $signed({1'b0, s_q, 16'b0});
		if (rel_c < 34'sd0) begin
			d_c = '0;
		end else if (rel_c > $signed({1'b0, span_fx_c})) begin
			d_c = span_fx_c;
		end else begin
			d_c = rel_c[32:0];
		end
		nraw_c   = fsel_q ? fout_q : fin_q;
		n_c      = (nraw_c > span_c) ? span_c : nraw_c;
		x_c      = fsel_q ? (span_fx_c - d_c) : d_c;
		nfx_c    = {n_c, 16'b0};
		bypass_c = (nraw_c == 17'd0) || (x_c >= nfx_c);
	end

	// iteration steps
	logic        div_ge_c, sq_ge_c;
	logic [19:0] rm2_c, trial_c;

	always_comb begin
		div_ge_c = rem_q >= dv_q;
		rm2_c    = {rm_q, rad_q[31:30]};
		trial_c  = {2'b0, root_q, 2'b01};
		sq_ge_c  = rm2_c >= trial_c;
	end

	// curve value
	logic [4:0]  cos_k_c;
	logic [5:0]  cos_k1_c;
	logic [16:0] cos_base_c, cos_diff_c, fv_c;
	curve_t      curve_c;

	always_comb begin
		cos_k_c    = q_q[15:11];
		cos_k1_c   = {1'b0, cos_k_c} + 6'd1;
		cos_base_c = COS_TAB[cos_k_c];
		cos_diff_c = COS_TAB[cos_k1_c] - cos_base_c;
		curve_c    = curve_t'(fsel_q ? mode_q[6:5] : mode_q[4:3]);
		if (byp_q) begin
			fv_c = UNITY;
		end else begin
			case (curve_c)
				CURVE_SQUARE: fv_c = {1'b0, mul_q[31:16]};
				CURVE_SQRT:   fv_c = {1'b0, root_q};
				CURVE_COSINE: fv_c = cos_base_c + mul_q[27:11];
				default:      fv_c = {1'b0, q_q};
			endcase
		end
	end

	// memory addressing
	logic [16:0]        lm2_c;
	logic [15:0]        i_c, rd_addr_c;
	logic               rd_en_c, rd_ok_c, wr_en_c;
	logic signed [16:0] dsmp_c;

	always_comb begin
		lm2_c     = l_q - 17'd2;
		i_c       = ({1'b0, p_q[31:16]} > lm2_c) ? lm2_c[15:0] : p_q[31:16];
		rd_addr_c = (cmd.op == OP_RD1) ? (i_c + 16'd1) : i_c;
		rd_en_c   = (cmd.op == OP_RD0) || (cmd.op == OP_RD1);
		rd_ok_c   = 25'(rd_addr_c) < DEPTH_V;
		wr_en_c   = (cmd.op == OP_ACCEPT) && (kind == KIND_WRITE)
			&& (25'(address) < DEPTH_V);
		dsmp_c    = {s2_q[15], s2_q} - {s1_q[15], s1_q};
	end

	// shared multiplier operands
	logic signed [33:0] mul_a_c;
	logic signed [17:0] mul_b_c;
	logic               mul_en_c;

	always_comb begin
		mul_a_c  = '0;
		mul_b_c  = '0;
		mul_en_c = 1'b1;
		case (cmd.op)
			OP_MUL_SQ: begin
				mul_a_c = {18'b0, q_q};
				mul_b_c = {2'b0, q_q};
			end
			OP_MUL_COS: begin
				mul_a_c = {17'b0, cos_diff_c};
				mul_b_c = {7'b0, q_q[10:0]};
			end
			OP_MUL_FT: begin
				mul_a_c = {17'b0, fi_q};
				mul_b_c = {1'b0, fo_q};
			end
			OP_MUL_INT: begin
				mul_a_c = {18'b0, p_q[15:0]};
				mul_b_c = {dsmp_c[16], dsmp_c};
			end
			OP_MUL_AMP: begin
				mul_a_c = acc_q;
				mul_b_c = {1'b0, ft_q};
			end
			OP_MUL_GAIN: begin
				mul_a_c = a1_q;
				mul_b_c = {2'b0, gain_q};
			end
			default: mul_en_c = 1'b0;
		endcase
	end

	// rounding, advance and output saturation
	logic signed [51:0] rnd1_c, rnd2_c;
	logic signed [33:0] pn_c;
	logic [31:0]        padv_c;
	logic signed [39:0] vx_c, sum_c;
	logic signed [23:0] mix_sat_c;
	logic signed [15:0] voice_sat_c;

	always_comb begin
		rnd1_c = mul_q + 52'sd32768;
		rnd2_c = mul_q + 52'sd536870912;
		if (back_q) begin
			pn_c = $signed({2'b0, p_q}) - $signed({10'b0, step_q});
		end else begin
			pn_c = $signed({2'b0, p_q}) + $signed({10'b0, step_q});
		end
		if (pn_c < 34'sd0) begin
			padv_c = '0;
		end else if (pn_c > $signed({2'b0, top_c})) begin
			padv_c = top_c;
		end else begin
			padv_c = pn_c[31:0];
		end
		vx_c  = 40'(voice_q);
		sum_c = 40'(mix_q) + (vx_c <<< SH);
		if (sum_c > 40'sd8388607) begin
			mix_sat_c = 24'sd8388607;
		end else if (sum_c < -40'sd8388608) begin
			mix_sat_c = -24'sd8388608;
		end else begin
			mix_sat_c = sum_c[23:0];
		end
		if (voice_q > 22'sd32767) begin
			voice_sat_c = 16'sd32767;
		end else if (voice_q < -22'sd32768) begin
			voice_sat_c = -16'sd32768;
		end else begin
			voice_sat_c = voice_q[15:0];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			end_q    <= UNITY;
			len_q    <= UNITY;
			step_q   <= 24'd65536;
			gain_q   <= 16'd16384;
			mode_q   <= '0;
			fin_q    <= '0;
			fout_q   <= '0;
			p_q      <= '0;
			back_q   <= 1'b0;
			active_q <= 1'b0;
			fsel_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_START:    start_q <= cfg_data[15:0];
					REG_END:      end_q   <= cfg_data[16:0];
					REG_LENGTH:   len_q   <= cfg_data[16:0];
					REG_STEP:     step_q  <= cfg_data;
					REG_GAIN:     gain_q  <= cfg_data[15:0];
					REG_MODE:     mode_q  <= cfg_data[6:0];
					REG_FADE_IN:  fin_q   <= cfg_data[16:0];
					REG_FADE_OUT: fout_q  <= cfg_data[16:0];
					default:      ;
				endcase
			end
			case (cmd.op)
				OP_START: begin
					back_q   <= mode_q[2];
					p_q      <= mode_q[2] ? thr_fwd_c : thr_bwd_c;
					active_q <= 1'b1;
				end
				OP_STOP: begin
					active_q <= 1'b0;
					p_q      <= '0;
				end
				OP_BOUND: begin
					fsel_q <= 1'b0;
					if (stop_c) begin
						active_q <= 1'b0;
						p_q      <= '0;
					end else if (mode_q[1:0] == MODE_LOOP) begin
						if (hit_fwd_c) begin
							p_q <= thr_bwd_c;
						end else if (hit_bwd_c) begin
							p_q <= thr_fwd_c;
						end
					end else if (mode_q[1:0] == MODE_PINGPONG) begin
						if (hit_fwd_c) begin
							back_q <= 1'b1;
							p_q    <= refl_fwd_c;
						end else if (hit_bwd_c) begin
							back_q <= 1'b0;
							p_q    <= refl_bwd_c;
						end
					end
				end
				OP_FSTORE:  fsel_q <= !fsel_q;
				OP_ADVANCE: p_q    <= padv_c;
				default:    ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (mul_en_c) begin
			mul_q <= mul_a_c * mul_b_c;
		end
		case (cmd.op)
			OP_ACCEPT: begin
				kind_q  <= kind;
				mix_q   <= mix_in;
				voice_q <= '0;
			end
			OP_RANGE: begin
				s_q <= s_c;
				e_q <= e_c;
				l_q <= l_c;
			end
			OP_FSETUP: begin
				rem_q <= x_c;
				dv_q  <= {1'b0, n_c, 15'b0};
				q_q   <= '0;
				byp_q <= bypass_c;
			end
			OP_DIV: begin
				if (div_ge_c) begin
					rem_q <= rem_q - dv_q;
				end
				q_q  <= {q_q[14:0], div_ge_c};
				dv_q <= dv_q >> 1;
			end
			OP_SQRT_LOAD: begin
				rad_q  <= {q_q, 16'b0};
				rm_q   <= '0;
				root_q <= '0;
			end
			OP_SQRT: begin
				rm_q   <= sq_ge_c ? 18'(rm2_c - trial_c) : rm2_c[17:0];
				root_q <= {root_q[14:0], sq_ge_c};
				rad_q  <= rad_q << 2;
			end
			OP_FSTORE: begin
				if (fsel_q) begin
					fo_q <= fv_c;
				end else begin
					fi_q <= fv_c;
				end
			end
			OP_RD0:  ft_q <= mul_q[32:16];
			OP_RD1:  s1_q <= rd_ok_q ? rdata_q : 16'sd0;
			OP_RD2:  s2_q <= rd_ok_q ? rdata_q : 16'sd0;
			OP_ACC:  acc_q <= $signed({{2{s1_q[15]}}, s1_q, 16'b0}) + mul_q[33:0];
			OP_RND:  a1_q <= rnd1_c[49:16];
			OP_ADVANCE: voice_q <= rnd2_c[51:30];
			OP_LOAD: begin
				out_mix_q    <= mix_sat_c;
				out_voice_q  <= voice_sat_c;
				out_active_q <= active_q;
				out_pos_q    <= p_q[31:16];
			end
			default: ;
		endcase
	end

	// sample memory
	always_ff @(posedge clk) begin
		if (wr_en_c) begin
			mem[AW'(address)] <= sample_in;
		end
		if (rd_en_c) begin
			rdata_q <= mem[AW'(rd_addr_c)];
			rd_ok_q <= rd_ok_c;
		end
	end

	always_comb begin
		status.kind   = item_kind_t'(kind_q);
		status.active = active_q;
		status.stop   = stop_c;
		status.bypass = bypass_c;
		status.fsel   = fsel_q;
		status.curve  = curve_c;
	end

	assign mix_out        = out_mix_q;
	assign voice_sample   = out_voice_q;
	assign voice_active   = out_active_q;
	assign position_index = out_pos_q;

endmodule

@@ rtl/sample_playback_voice.sv @@
// Top level of the one-voice sample player with linear interpolation.
//
// Channels: item carries write, start, stop and tick beats; result returns
// exactly one beat per item; cfg writes the eight setting registers and is
// always ready. The user must write settings only while the voice has no
// item in flight; the block itself does not enforce this. A playing tick
// uses one shared multiplier; each enabled fade runs a bit-per-cycle
// divider, then multiplies for a square or raised cosine curve or runs
// a bit-per-cycle root unit for a square root.
// Throughput: one item at a time; the next item is taken once the previous
// result sits in the output register, even if it has not yet been taken.
// Reset clears the voice (idle, position zero) and loads the register
// defaults; the sample memory holds no defined contents until written.
// When the receiver stalls, the finished result is held and the block
// waits with its next result until the output register is free.
`timescale 1ns / 1ps

module sample_playback_voice #(
	parameter int MEMORY_DEPTH = 65536,
	parameter int SAMPLE_BITS  = 16
) (
	input logic      clk,
	input logic      arst_n,
	spv_cfg_if.sink  cfg,
	spv_in_if.sink   item,
	spv_out_if.source result
);
	import spv_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg.ready = 1'b1;

	spv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	spv_dp #(
		.MEMORY_DEPTH (MEMORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.kind           (item.kind),
		.address        (item.address),
		.sample_in      (item.sample_in),
		.mix_in         (item.mix_in),
		.mix_out        (result.mix_out),
		.voice_sample   (result.voice_sample),
		.voice_active   (result.voice_active),
		.position_index (result.position_index)
	);

endmodule

@@ rtl/spv_checker.sv @@
// Port-level assertions for the sample playback voice, bound to the top level.
`timescale 1ns / 1ps

module spv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_active,
	input logic [15:0] res_voice,
	input logic [15:0] res_pos
);

	// a stalled result beat stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	// one item in flight: no beat accepted straight after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while previous one in flight");

	// an idle voice always sits at position zero
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_active |-> res_pos == 16'd0)
		else $error("idle voice reports non-zero position");

	// sound only comes from a playing voice
	a_voice_active: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_voice != 16'd0 |-> res_active)
		else $error("voice output from an idle voice");

endmodule

bind sample_playback_voice spv_checker u_spv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_active (result.voice_active),
	.res_voice  (result.voice_sample),
	.res_pos    (result.position_index)
);
